@@ rtl/pidc_pkg.sv @@
package pidc_pkg;

  // Depth of the derivative history window (2 to 64).
  localparam int WINDOW = 4;
  localparam int WIN_IDX_W = $clog2(WINDOW);
  // Width of a sum of up to WINDOW time steps.
  localparam int SUM_W = 16 + WIN_IDX_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_TERM_MIN = 3'd3;
  localparam logic [2:0] REG_TERM_MAX = 3'd4;
  localparam logic [2:0] REG_OUT_GAIN = 3'd5;
  localparam logic [2:0] REG_OUT_MIN  = 3'd6;
  localparam logic [2:0] REG_OUT_MAX  = 3'd7;

  localparam logic [0:0] OP_SAMPLE = 1'b0;
  localparam logic [0:0] OP_PRESET = 1'b1;

  // Request into the serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // Response from the serial divider.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // Magnitude of a signed 32-bit value as an unsigned 32-bit value.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

  // Clamp a signed 64-bit value into [lo, hi].
  function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
    logic signed [63:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

@@ rtl/pidc_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module pidc_div (
  input  logic               clk,
  input  logic               rst,
  input  pidc_pkg::div_req_t req,
  output pidc_pkg::div_rsp_t rsp
);

  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[63]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 6'd63);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
        quo <= {quo[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ rtl/pid_controller_saturating.sv @@
// PID controller with anti-windup, Q16.16 fixed point.
// Input channel: in_valid/in_stall carry one word of operation, error_sample,
// time_step and integ_preset. A preset word loads the integrator and gives no
// result. A sample word gives one control_out word on the out_valid/out_stall
// channel.
// A sample passes through one shared 32x32 multiplier and one serial divider
// that yields a quotient bit per cycle; each division holds the sequencer
// until it is done. With ki zero a sample uses one division, for the
// derivative. With ki nonzero the two integrator bounds add two divisions
// and a clamp state. When the derivative window time is zero the derivative
// division is skipped.
// in_stall is high from the cycle after a sample is accepted until its result
// has been placed in the output register. That register holds the result
// while the receiver stalls, so the next word can be accepted while the
// previous result still waits; a stalled earlier result delays the load.
// Reset (rst, synchronous) restores the configuration defaults, clears the
// integrator, the error and step history, and drops out_valid.
module pid_controller_saturating (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [31:0] error_sample,
  input  logic [15:0]        time_step,
  input  logic signed [31:0] integ_preset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] control_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_P_MUL, S_INC_MUL, S_ACC_ADD, S_LO_WAIT, S_HI_WAIT, S_ACC_CLAMP,
    S_I_LO, S_I_HI, S_D_MUL, S_D_DIV, S_D_WAIT, S_O_LO, S_O_HI, S_O_FIN, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] kp, kd, term_min, term_max, out_gain, out_min, out_max;
  logic [30:0]        ki;

  // Controller state.
  logic signed [63:0] integ_acc;
  logic signed [31:0] past_errors [pidc_pkg::WINDOW];
  logic [15:0]        past_steps [pidc_pkg::WINDOW];
  logic [pidc_pkg::SUM_W-1:0] step_window_sum;

  // Per-sample working registers.
  logic signed [31:0] err;
  logic [15:0]        step;
  logic signed [31:0] p_term, i_term, d_term;
  logic signed [63:0] blo, bhi;
  logic [31:0]        ilo;
  logic [63:0]        olo;
  logic signed [31:0] y_reg;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod;

  pidc_pkg::div_req_t div_req;
  pidc_pkg::div_rsp_t div_rsp;

  pidc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sorted limits.
  logic signed [31:0] tlo, thi, olim_lo, olim_hi;
  assign tlo     = (term_min < term_max) ? term_min : term_max;
  assign thi     = (term_min < term_max) ? term_max : term_min;
  assign olim_lo = (out_min < out_max) ? out_min : out_max;
  assign olim_hi = (out_min < out_max) ? out_max : out_min;

  logic signed [63:0] tlo64, thi64;
  assign tlo64 = 64'(tlo);
  assign thi64 = 64'(thi);

  logic [63:0]        acc_mag;
  logic signed [32:0] diff;
  logic [31:0]        diff_mag;
  logic [pidc_pkg::SUM_W-1:0] denom;
  logic signed [33:0] term_sum;
  logic [33:0]        sum_mag;

  assign acc_mag  = integ_acc[63] ? 64'(-integ_acc) : 64'(integ_acc);
  assign diff     = 33'(err) - 33'(past_errors[0]);
  assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
  assign denom    = pidc_pkg::SUM_W'(step) + step_window_sum;
  assign term_sum = 34'(p_term) + 34'(i_term) + 34'(d_term);
  assign sum_mag  = term_sum[33] ? 34'(-term_sum) : 34'(term_sum);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P_MUL: begin
        mul_a = pidc_pkg::mag32(kp);
        mul_b = pidc_pkg::mag32(err);
      end
      S_INC_MUL: begin
        mul_a = pidc_pkg::mag32(err);
        mul_b = 32'(step);
      end
      S_I_LO: begin
        mul_a = 32'(ki);
        mul_b = acc_mag[31:0];
      end
      S_I_HI: begin
        mul_a = 32'(ki);
        mul_b = acc_mag[63:32];
      end
      S_D_MUL: begin
        mul_a = pidc_pkg::mag32(kd);
        mul_b = diff_mag;
      end
      S_O_LO: begin
        mul_a = sum_mag[31:0];
        mul_b = pidc_pkg::mag32(out_gain);
      end
      S_O_HI: begin
        mul_a = 32'(sum_mag[33:32]);
        mul_b = pidc_pkg::mag32(out_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Signed results taken from the multiplier or divider output.
  logic signed [63:0] p_raw, inc, i_raw, d_raw, y_raw, q_signed;
  logic [63:0]        i_m, o_m;
  logic [64:0]        acc_sum;
  logic signed [63:0] acc_sat;

  assign p_raw = (kp[31] ^ err[31]) ? -64'(prod >> 16) : 64'(prod >> 16);
  assign inc   = err[31] ? -64'(prod) : 64'(prod);
  assign acc_sum = {integ_acc[63], integ_acc} + {inc[63], inc};
  assign acc_sat = (acc_sum[64] != acc_sum[63]) ?
                   (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) :
                   acc_sum[63:0];
  assign i_m   = prod + 64'(ilo);
  assign i_raw = integ_acc[63] ? -64'(i_m) : 64'(i_m);
  assign d_raw = (kd[31] ^ diff[32]) ? -64'(div_rsp.quotient) : 64'(div_rsp.quotient);
  assign o_m   = olo + {prod[31:0], 32'd0};
  assign y_raw = (term_sum[33] ^ out_gain[31]) ? -64'(o_m >> 16) : 64'(o_m >> 16);

  logic bound_neg;
  assign bound_neg = (state == S_LO_WAIT) ? tlo[31] : thi[31];
  assign q_signed  = bound_neg ? -64'(div_rsp.quotient) : 64'(div_rsp.quotient);

  // When ki is nonzero a division starts for the low bound, then the high
  // bound; one starts for the derivative when the window time is nonzero.
  logic div_start;
  assign div_start = ((state == S_ACC_ADD) && (ki != '0)) ||
                     ((state == S_LO_WAIT) && div_rsp.done) ||
                     ((state == S_D_DIV) && (denom != '0));

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      kp              <= 32'sd65536;
      ki              <= '0;
      kd              <= '0;
      term_min        <= -32'sd65536;
      term_max        <= 32'sd65536;
      out_gain        <= 32'sd65536;
      out_min         <= -32'sd65536;
      out_max         <= 32'sd65536;
      integ_acc       <= '0;
      step_window_sum <= '0;
      for (int k = 0; k < pidc_pkg::WINDOW; k++) begin
        past_errors[k] <= '0;
        past_steps[k]  <= '0;
      end
      out_valid       <= 1'b0;
      div_req         <= '0;
    end else begin
      prod          <= mul_p;
      div_req.start <= div_start;
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          pidc_pkg::REG_KP:       kp       <= cfg_data;
          pidc_pkg::REG_KI:       ki       <= cfg_data[30:0];
          pidc_pkg::REG_KD:       kd       <= cfg_data;
          pidc_pkg::REG_TERM_MIN: term_min <= cfg_data;
          pidc_pkg::REG_TERM_MAX: term_max <= cfg_data;
          pidc_pkg::REG_OUT_GAIN: out_gain <= cfg_data;
          pidc_pkg::REG_OUT_MIN:  out_min  <= cfg_data;
          pidc_pkg::REG_OUT_MAX:  out_max  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (operation == pidc_pkg::OP_PRESET) begin
              integ_acc <= 64'(integ_preset) <<< 16;
            end else begin
              err   <= error_sample;
              step  <= time_step;
              state <= S_P_MUL;
            end
          end
        end
        S_P_MUL: begin
          state <= S_INC_MUL;
        end
        S_INC_MUL: begin
          p_term <= 32'(pidc_pkg::clamp64(p_raw, tlo64, thi64));
          state  <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          integ_acc <= acc_sat;
          if (ki != '0) begin
            div_req.dividend <= {pidc_pkg::mag32(tlo), 32'd0};
            div_req.divisor  <= 32'(ki);
            state            <= S_LO_WAIT;
          end else begin
            state <= S_I_LO;
          end
        end
        S_LO_WAIT: begin
          if (div_rsp.done) begin
            blo              <= q_signed;
            div_req.dividend <= {pidc_pkg::mag32(thi), 32'd0};
            div_req.divisor  <= 32'(ki);
            state            <= S_HI_WAIT;
          end
        end
        S_HI_WAIT: begin
          if (div_rsp.done) begin
            bhi   <= q_signed;
            state <= S_ACC_CLAMP;
          end
        end
        S_ACC_CLAMP: begin
          integ_acc <= pidc_pkg::clamp64(integ_acc, blo, bhi);
          state     <= S_I_LO;
        end
        S_I_LO: begin
          state <= S_I_HI;
        end
        S_I_HI: begin
          ilo   <= prod[63:32];
          state <= S_D_MUL;
        end
        S_D_MUL: begin
          i_term <= 32'(pidc_pkg::clamp64(i_raw, tlo64, thi64));
          state  <= S_D_DIV;
        end
        S_D_DIV: begin
          if (denom == '0) begin
            d_term <= 32'(pidc_pkg::clamp64(64'sd0, tlo64, thi64));
            state  <= S_O_LO;
          end else begin
            div_req.dividend <= prod;
            div_req.divisor  <= 32'(denom);
            state            <= S_D_WAIT;
          end
        end
        S_D_WAIT: begin
          if (div_rsp.done) begin
            d_term <= 32'(pidc_pkg::clamp64(d_raw, tlo64, thi64));
            state  <= S_O_LO;
          end
        end
        S_O_LO: begin
          state <= S_O_HI;
        end
        S_O_HI: begin
          olo   <= prod;
          state <= S_O_FIN;
        end
        S_O_FIN: begin
          y_reg <= 32'(pidc_pkg::clamp64(y_raw, 64'(olim_lo), 64'(olim_hi)));
          // Slide the history window; the sum covers entries 1 to WINDOW-1.
          step_window_sum <= step_window_sum - pidc_pkg::SUM_W'(past_steps[1])
                             + pidc_pkg::SUM_W'(step);
          for (int k = 1; k < pidc_pkg::WINDOW; k++) begin
            past_errors[k-1] <= past_errors[k];
            past_steps[k-1]  <= past_steps[k];
          end
          past_errors[pidc_pkg::WINDOW-1] <= err;
          past_steps[pidc_pkg::WINDOW-1]  <= step;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            control_out <= y_reg;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider is never left running while the block is idle.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // An accepted sample holds off the next word.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == pidc_pkg::OP_SAMPLE) |=> in_stall)
    else $error("sample accepted but block not busy");

  // A new result appears only from the output hand-off state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result word raised outside output state");

endmodule
